/* hdl/rio_pkg.sv */
// Package for the range image outlier mask: word types, the job record passed
// from the front end to the evaluator, and sizing constants. No dependencies.
package rio_pkg;

  // Largest band width the column counter supports.
  localparam int unsigned MaxColumns = 256;
  // Width of a column index and of the band width register.
  localparam int unsigned ColW = 9;
  // The column counter saturates here, past any judged column.
  localparam int unsigned CountCap = MaxColumns + 3;
  // Depth of the job queue between front and back and its pointer width.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  typedef logic [15:0] sample_t;
  typedef logic [ColW-1:0] col_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BAND_WIDTH = 2'd0,
    CFG_NEAR_TOL   = 2'd1,
    CFG_MID_TOL    = 2'd2,
    CFG_FAR_TOL    = 2'd3
  } cfg_index_e;

  // One input word: a column of five range samples.
  typedef struct packed {
    sample_t sample_row0;
    sample_t sample_row1;
    sample_t sample_row2;
    sample_t sample_row3;
    sample_t sample_row4;
    logic    band_start;
  } in_word_t;

  // One output word: the verdict on a centre sample.
  typedef struct packed {
    logic keep;
    col_t column_index;
    logic band_last;
  } out_word_t;

  // Everything the evaluator needs to judge one centre sample.
  typedef struct packed {
    sample_t           centre;     // the judged sample d
    sample_t           tol;        // tolerance picked by range segment
    logic              need_side;  // segment above 2
    sample_t [2:0]     left_rows;  // rows 1..3 of the left column
    sample_t [3:0]     ctr_rows;   // rows 0, 1, 3, 4 of the centre column
    sample_t [2:0]     right_rows; // rows 1..3 of the right column
    col_t              col;
    logic              last;
  } job_t;

  // Push request from the front end into the job queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

endpackage

/* hdl/rio_front.sv */
// Front end of the outlier mask: configuration registers, the two-column
// window, the band column counter and job building. Uses rio_pkg.
module rio_front
  import rio_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic       accept_i,
  input  in_word_t   in_word_i,
  output job_push_t  push_o
);

  col_t    band_width_q;
  sample_t near_tol_q;
  sample_t mid_tol_q;
  sample_t far_tol_q;

  sample_t older_q [5];
  sample_t newer_q [5];
  sample_t cur [5];

  col_t    seen_q;
  col_t    seen_d;
  col_t    width;
  col_t    col;
  logic [3:0] seg_hi;
  logic    produce;

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_width_q <= col_t'(MaxColumns);
      near_tol_q   <= sample_t'(128);
      mid_tol_q    <= sample_t'(200);
      far_tol_q    <= sample_t'(300);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_BAND_WIDTH: band_width_q <= cfg_wdata_i[ColW-1:0];
        CFG_NEAR_TOL:   near_tol_q   <= cfg_wdata_i;
        CFG_MID_TOL:    mid_tol_q    <= cfg_wdata_i;
        CFG_FAR_TOL:    far_tol_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cur[0] = in_word_i.sample_row0;
  assign cur[1] = in_word_i.sample_row1;
  assign cur[2] = in_word_i.sample_row2;
  assign cur[3] = in_word_i.sample_row3;
  assign cur[4] = in_word_i.sample_row4;

  // Column counter: a band start restarts at the halo, otherwise count up and saturate.
  always_comb begin
    if (in_word_i.band_start) begin
      seen_d = col_t'(1);
    end else if (seen_q < col_t'(CountCap)) begin
      seen_d = seen_q + col_t'(1);
    end else begin
      seen_d = seen_q;
    end
  end

  // A result is due once three columns are in and the judged column is in the band.
  assign width   = (band_width_q > col_t'(MaxColumns)) ? col_t'(MaxColumns) : band_width_q;
  assign col     = seen_d - col_t'(2);
  assign produce = accept_i && (seen_d >= col_t'(3)) && (col <= width);
  assign seg_hi  = newer_q[2][15:12];

  // Build the job from the window and the arriving column.
  always_comb begin
    push_o.valid                = produce;
    push_o.job.centre           = newer_q[2];
    push_o.job.need_side        = (seg_hi > 4'd2);
    if (seg_hi <= 4'd2) begin
      push_o.job.tol = near_tol_q;
    end else if (seg_hi <= 4'd8) begin
      push_o.job.tol = mid_tol_q;
    end else begin
      push_o.job.tol = far_tol_q;
    end
    push_o.job.left_rows[0]  = older_q[1];
    push_o.job.left_rows[1]  = older_q[2];
    push_o.job.left_rows[2]  = older_q[3];
    push_o.job.ctr_rows[0]   = newer_q[0];
    push_o.job.ctr_rows[1]   = newer_q[1];
    push_o.job.ctr_rows[2]   = newer_q[3];
    push_o.job.ctr_rows[3]   = newer_q[4];
    push_o.job.right_rows[0] = cur[1];
    push_o.job.right_rows[1] = cur[2];
    push_o.job.right_rows[2] = cur[3];
    push_o.job.col           = col;
    push_o.job.last          = (col == width);
  end

  // Counter and column window advance on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int i = 0; i < 5; i++) begin
        older_q[i] <= '0;
        newer_q[i] <= '0;
      end
    end else if (accept_i) begin
      seen_q <= seen_d;
      for (int i = 0; i < 5; i++) begin
        older_q[i] <= newer_q[i];
        newer_q[i] <= cur[i];
      end
    end
  end

endmodule

/* hdl/rio_queue.sv */
// Short job queue between the front end and the evaluator, so each side can
// stall on its own. Uses rio_pkg.
module rio_queue
  import rio_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_push_t push_i,
  output logic      full_o,
  output logic      valid_o,
  output job_t      job_o,
  input  logic      pop_i
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueuePtrW:0]   count_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hdl/rio_back.sv */
// Evaluator of the outlier mask: neighbor compares, counts and the keep rule,
// with a registered output word. Uses rio_pkg.
module rio_back
  import rio_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output out_word_t out_word_o,
  input  logic      out_stall_i
);

  function automatic logic in_tol(sample_t x, sample_t d, sample_t tol);
    sample_t diff;
    diff = (x > d) ? (x - d) : (d - x);
    return (diff <= tol);
  endfunction

  logic       valid;
  logic       v0, v1, v3, v4;
  logic [2:0] cnt;
  logic [1:0] side;
  logic [1:0] outer;
  logic [2:0] neib;
  logic       side_ok, strong_hit, weak_hit, pass, keep;
  logic       out_valid_q;
  out_word_t  out_word_q;

  // Compare each neighbor against the centre sample.
  always_comb begin
    valid = (job_i.centre != '0);
    v0    = in_tol(job_i.ctr_rows[0], job_i.centre, job_i.tol);
    v1    = in_tol(job_i.ctr_rows[1], job_i.centre, job_i.tol);
    v3    = in_tol(job_i.ctr_rows[2], job_i.centre, job_i.tol);
    v4    = in_tol(job_i.ctr_rows[3], job_i.centre, job_i.tol);
    neib  = '0;
    for (int i = 0; i < 3; i++) begin
      neib = neib + 3'(in_tol(job_i.left_rows[i], job_i.centre, job_i.tol))
                  + 3'(in_tol(job_i.right_rows[i], job_i.centre, job_i.tol));
    end
  end

  // Counts and the keep decision.
  always_comb begin
    cnt        = 3'(v0) + 3'(v1) + 3'(valid) + 3'(v3) + 3'(v4);
    side       = 2'(v1) + 2'(v3);
    outer      = 2'(v0) + 2'(v4);
    side_ok    = (side >= 2'(job_i.need_side));
    strong_hit = side_ok && (cnt > 3'd2);
    weak_hit   = side_ok && (cnt <= 3'd2);
    pass       = ((4'(neib) + 4'(side)) >= 4'd1)
              || (job_i.last && side_ok)
              || ((3'(outer) + 3'(side)) >= 3'd2);
    keep       = valid && (strong_hit || (weak_hit && pass));
  end

  // Output register loads whenever it is empty or being taken.
  assign pop_o = job_valid_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_word_q.keep         <= keep;
      out_word_q.column_index <= job_i.col;
      out_word_q.band_last    <= job_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* hdl/range_image_outlier_mask.sv */
// Range image outlier mask. One column word of five range samples is taken per
// clock; after the halo column and one more column of a band, each new word
// yields one verdict on the centre sample of the previous column, up to the
// configured band width. A verdict's job enters the job queue as its column is
// taken, and the compare stage loads it into the output register as it leaves the
// queue. Sustained rate is one word per cycle; the input stalls only when the
// four-entry job queue is full, which happens only while the output side stalls.
// Write configuration only while the block is idle.
// Depends on rio_pkg, rio_front, rio_queue and rio_back.
module range_image_outlier_mask
  import rio_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  logic      accept;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  job_t      q_job;
  job_push_t push;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  rio_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_word_i   (in_word_i),
    .push_o      (push)
  );

  rio_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (q_job),
    .pop_i   (q_pop)
  );

  rio_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (q_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

endmodule

/* bench/range_image_outlier_mask_tb.sv */
// Self-checking testbench for range_image_outlier_mask: a directed table of column
// words, then random bands under several register settings and handshake idling.
// Depends on rio_pkg and the range_image_outlier_mask RTL.
module range_image_outlier_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rio_pkg::*;

  localparam int unsigned ResetCycles    = 10;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned PressureCycles = 80;
  localparam int unsigned MaxReports     = 10;

  // How the expectation of a table row is formed.
  typedef enum {
    CHECK_MODEL,
    EXPECT_NONE,
    EXPECT_WORD
  } exp_kind_e;

  typedef struct {
    in_word_t  word;
    exp_kind_e kind;
    out_word_t want;
  } stim_row_t;

  typedef struct {
    logic [15:0] width_word;
    sample_t     near_tol;
    sample_t     mid_tol;
    sample_t     far_tol;
    int unsigned snd_pct;
    int unsigned rcv_pct;
    int unsigned items;
    bit          squeeze;
  } phase_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  cfg_index_e cfg_index;
  logic [15:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;

  // Shadow of the block: registers, the two held columns and the column count.
  col_t        band_width_q;
  sample_t     near_tol_q;
  sample_t     mid_tol_q;
  sample_t     far_tol_q;
  sample_t     left_col[5];
  sample_t     centre_col[5];
  int unsigned cols_seen;

  out_word_t   verdict_q[$];
  int unsigned error_cnt;
  int unsigned idle_cycles;
  int unsigned snd_pct;
  int unsigned rcv_pct;
  bit          pressure_req;

  range_image_outlier_mask i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Range segment of a sample, clamped to the far end.
  function automatic int unsigned segment_of(sample_t d);
    int unsigned seg;
    seg = d >> 12;
    return (seg > 11) ? 11 : seg;
  endfunction

  function automatic sample_t tol_for(sample_t d);
    int unsigned seg;
    seg = segment_of(d);
    if (seg <= 2) return near_tol_q;
    if (seg <= 8) return mid_tol_q;
    return far_tol_q;
  endfunction

  function automatic int unsigned within_tol(sample_t x, sample_t d, sample_t tol);
    sample_t diff;
    diff = (x > d) ? x - d : d - x;
    return (diff <= tol) ? 1 : 0;
  endfunction

  // Advance the shadow by one column word and form the verdict it releases.
  task automatic judge_column(input in_word_t w, output bit made, output out_word_t v);
    sample_t     cur[5];
    sample_t     d;
    sample_t     tol;
    int unsigned width_eff, col, need, valid, v0, v1, v3, v4, cnt, side;
    int unsigned outer, neib, r;
    bit          side_ok, many, weak_hit, strong_hit, pass, last;
    cur[0] = w.sample_row0;
    cur[1] = w.sample_row1;
    cur[2] = w.sample_row2;
    cur[3] = w.sample_row3;
    cur[4] = w.sample_row4;
    made = 1'b0;
    v = '0;
    if (w.band_start) cols_seen = 1;
    else if (cols_seen < CountCap) cols_seen++;

    width_eff = (band_width_q > MaxColumns) ? MaxColumns : band_width_q;
    col = cols_seen - 2;
    if (cols_seen >= 3 && col <= width_eff) begin
      d = centre_col[2];
      valid = (d != 0) ? 1 : 0;
      need = (segment_of(d) > 2) ? 1 : 0;
      tol = tol_for(d);
      v0 = within_tol(centre_col[0], d, tol);
      v1 = within_tol(centre_col[1], d, tol);
      v3 = within_tol(centre_col[3], d, tol);
      v4 = within_tol(centre_col[4], d, tol);
      cnt = v0 + v1 + valid + v3 + v4;
      side = v1 + v3;
      side_ok = side >= need;
      many = cnt > 2;
      weak_hit = side_ok && !many;
      strong_hit = side_ok && many;
      last = col == width_eff;
      outer = 0;
      neib = 0;
      // A weak sample may still pass on its neighbours in the side columns.
      if (weak_hit) begin
        outer = v0 + v4;
        for (r = 1; r < 4; r++) begin
          neib += within_tol(left_col[r], d, tol) + within_tol(cur[r], d, tol);
        end
      end
      pass = (neib + side >= 1) || (last && side_ok) || (outer + side >= 2);
      v.keep = (valid != 0) && (strong_hit || (weak_hit && pass));
      v.column_index = col_t'(col);
      v.band_last = last;
      made = 1'b1;
    end

    for (r = 0; r < 5; r++) begin
      left_col[r] = centre_col[r];
      centre_col[r] = cur[r];
    end
  endtask

  task automatic note_failure(string msg);
    if (error_cnt < MaxReports) $display("%0t: %s", $realtime, msg);
    error_cnt++;
  endtask

  // Register write at the current falling edge; the shadow follows.
  task automatic write_cfg(cfg_index_e idx, logic [15:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    case (idx)
      CFG_BAND_WIDTH: band_width_q = data[ColW-1:0];
      CFG_NEAR_TOL:   near_tol_q = data;
      CFG_MID_TOL:    mid_tol_q = data;
      CFG_FAR_TOL:    far_tol_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one word, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_word(in_word_t w, exp_kind_e kind, out_word_t typed);
    bit        made;
    out_word_t v;
    while ($urandom_range(0, 99) < snd_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_word = w;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    judge_column(w, made, v);
    if (kind == EXPECT_WORD) verdict_q.push_back(typed);
    else if (kind == CHECK_MODEL && made) verdict_q.push_back(v);
    @(negedge clk);
  endtask

  // Wait for every verdict to arrive, then for the pipeline to run dry.
  task automatic wait_idle();
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic stim_row_t step_row(sample_t r0, sample_t r1, sample_t r2,
                                         sample_t r3, sample_t r4, logic start,
                                         exp_kind_e kind, logic keep, col_t col,
                                         logic last);
    stim_row_t s;
    s.word.sample_row0 = r0;
    s.word.sample_row1 = r1;
    s.word.sample_row2 = r2;
    s.word.sample_row3 = r3;
    s.word.sample_row4 = r4;
    s.word.band_start = start;
    s.kind = kind;
    s.want.keep = keep;
    s.want.column_index = col;
    s.want.band_last = last;
    return s;
  endfunction

  // A sample scattered around base, reaching a little past the tolerance.
  function automatic sample_t near_value(sample_t base, sample_t tol);
    int span;
    int v;
    span = int'(tol) + int'(tol) / 2 + 2;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return sample_t'(v);
  endfunction

  function automatic sample_t pick_base();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 5) return '0;
    if (p < 10) return 16'hFFFF;
    return sample_t'($urandom);
  endfunction

  // One column around a base range: mostly close rows, some equal, random or zero.
  function automatic in_word_t make_column(sample_t base);
    sample_t     rows[5];
    sample_t     tol;
    int unsigned p, r;
    in_word_t    w;
    tol = tol_for(base);
    for (r = 0; r < 5; r++) begin
      p = $urandom_range(0, 99);
      if (r == 2 && p < 80) rows[r] = base;
      else if (p < 55) rows[r] = near_value(base, tol);
      else if (p < 70) rows[r] = base;
      else if (p < 88) rows[r] = sample_t'($urandom);
      else rows[r] = '0;
    end
    w.sample_row0 = rows[0];
    w.sample_row1 = rows[1];
    w.sample_row2 = rows[2];
    w.sample_row3 = rows[3];
    w.sample_row4 = rows[4];
    w.band_start = 1'b0;
    return w;
  endfunction

  // Random bands: mostly complete ones with a halo on each side, some cut short,
  // some without a start marker, and a rare restart in the middle.
  task automatic run_bands(int unsigned n_items);
    int unsigned sent, len, k, w_eff;
    sample_t     base;
    in_word_t    w;
    sent = 0;
    while (sent < n_items) begin
      w_eff = (band_width_q > MaxColumns) ? MaxColumns : band_width_q;
      if ($urandom_range(0, 99) < 80) len = w_eff + 1 + $urandom_range(0, 3);
      else len = $urandom_range(0, w_eff + 2);
      base = pick_base();
      for (k = 0; k <= len && sent < n_items; k++) begin
        w = make_column(base);
        if (k == 0) w.band_start = $urandom_range(0, 99) < 92;
        else w.band_start = $urandom_range(0, 399) == 0;
        send_word(w, CHECK_MODEL, '0);
        sent++;
        base = near_value(base, tol_for(base) / 2);
      end
    end
  endtask

  // Receiver stall: random idling, plus one long hold-off when asked for.
  initial begin : recv_stall
    int unsigned hold_left;
    bit          squeezed;
    hold_left = 0;
    squeezed = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (pressure_req && !squeezed) begin
        squeezed = 1'b1;
        hold_left = PressureCycles - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = $urandom_range(0, 99) < rcv_pct;
      end
    end
  end

  // Verdict checker: every accepted word against the oldest expectation.
  always @(posedge clk) begin : check_verdict
    out_word_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (verdict_q.size() == 0) begin
        note_failure($sformatf("unexpected verdict keep %0b col %0d last %0b",
                               out_word.keep, out_word.column_index, out_word.band_last));
      end else begin
        want = verdict_q.pop_front();
        if (out_word.keep !== want.keep || out_word.column_index !== want.column_index ||
            out_word.band_last !== want.band_last) begin
          note_failure($sformatf(
              "verdict mismatch: expected keep %0b col %0d last %0b, got keep %0b col %0d last %0b",
              want.keep, want.column_index, want.band_last,
              out_word.keep, out_word.column_index, out_word.band_last));
        end
      end
    end
  end

  // Watchdog on cycles where neither side moves a word.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("** range_image_outlier_mask: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main
    phase_t      plan[6];
    stim_row_t   script[$];
    int unsigned i;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BAND_WIDTH;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_word = '0;
    error_cnt = 0;
    idle_cycles = 0;
    pressure_req = 1'b0;
    snd_pct = 20;
    rcv_pct = 59;
    band_width_q = col_t'(MaxColumns);
    near_tol_q = 16'd128;
    mid_tol_q = 16'd200;
    far_tol_q = 16'd300;
    cols_seen = 0;
    for (i = 0; i < 5; i++) begin
      left_col[i] = '0;
      centre_col[i] = '0;
    end

    // Directed words under the reset settings. The first column carries no start
    // marker and acts as the halo; later a band restarts in mid stream.
    script.push_back(step_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                              EXPECT_NONE, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                              EXPECT_NONE, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0,
                              EXPECT_WORD, 1'b0, 9'd1, 1'b0));
    script.push_back(step_row(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 1'b0,
                              EXPECT_WORD, 1'b1, 9'd2, 1'b0));
    script.push_back(step_row(16'd1000, 16'd5000, 16'd1000, 16'd5000, 16'd1000, 1'b0,
                              EXPECT_WORD, 1'b0, 9'd3, 1'b0));
    // Segment and tolerance boundaries on both sides.
    script.push_back(step_row(16'h307F, 16'h2F7E, 16'h2FFF, 16'h3100, 16'h0000, 1'b0,
                              CHECK_MODEL, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'h3000, 16'h2F38, 16'h3000, 16'h30C9, 16'h0000, 1'b0,
                              CHECK_MODEL, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'h0000, 16'h912C, 16'h9000, 16'h0000, 16'h0000, 1'b0,
                              CHECK_MODEL, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'h0000, 16'h0000, 16'h8FFF, 16'h0000, 16'h0000, 1'b0,
                              CHECK_MODEL, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'hFFFF, 16'hC000, 16'hC000, 16'hC12C, 16'hFFFF, 1'b0,
                              CHECK_MODEL, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 1'b1,
                              EXPECT_NONE, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'h0080, 16'h0000, 16'h0001, 16'h0081, 16'hFFFE, 1'b0,
                              EXPECT_NONE, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                              CHECK_MODEL, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                              EXPECT_WORD, 1'b0, 9'd2, 1'b0));
    script.push_back(step_row(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0,
                              CHECK_MODEL, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0,
                              CHECK_MODEL, 1'b0, 9'd0, 1'b0));
    // A lone sample with no close neighbour anywhere is marked as noise.
    script.push_back(step_row(16'h4000, 16'h0100, 16'h0800, 16'h0F00, 16'h7000, 1'b0,
                              CHECK_MODEL, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'h0000, 16'h2000, 16'h3000, 16'h2000, 16'h0000, 1'b0,
                              CHECK_MODEL, 1'b0, 9'd0, 1'b0));
    script.push_back(step_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                              CHECK_MODEL, 1'b0, 9'd0, 1'b0));

    // Random phases: width word, near, mid, far, sender and receiver idle rates,
    // words, long hold-off. The first width word carries junk above bit 8.
    plan[0] = '{16'hFE05, 16'd128, 16'd200, 16'd300, 20, 59, 300, 1'b0};
    plan[1] = '{16'd1, 16'd0, 16'd0, 16'd0, 20, 59, 200, 1'b0};
    plan[2] = '{16'd256, 16'hFFFF, 16'hFFFF, 16'hFFFF, 59, 20, 280, 1'b0};
    plan[3] = '{16'd0, 16'd700, 16'd40, 16'd9000, 59, 20, 40, 1'b0};
    plan[4] = '{16'd511, 16'd1000, 16'd50, 16'd2000, 0, 0, 280, 1'b1};
    plan[5] = '{16'd12, 16'd64, 16'd150, 16'd400, 0, 0, 480, 1'b0};

    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (script[k]) send_word(script[k].word, script[k].kind, script[k].want);
    in_valid = 1'b0;
    wait_idle();

    for (i = 0; i < 6; i++) begin
      write_cfg(CFG_BAND_WIDTH, plan[i].width_word);
      write_cfg(CFG_NEAR_TOL, plan[i].near_tol);
      write_cfg(CFG_MID_TOL, plan[i].mid_tol);
      write_cfg(CFG_FAR_TOL, plan[i].far_tol);
      snd_pct = plan[i].snd_pct;
      rcv_pct = plan[i].rcv_pct;
      if (plan[i].squeeze) pressure_req = 1'b1;
      run_bands(plan[i].items);
      in_valid = 1'b0;
      wait_idle();
    end

    if (error_cnt == 0 && verdict_q.size() == 0) begin
      $display("** range_image_outlier_mask: PASSED **");
    end else begin
      $display("** range_image_outlier_mask: FAILED **");
    end
    $finish;
  end

endmodule
